// ===== rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg: shared types and constants of the page-table walker
// Item structs, entry bit positions, state and unit codes, index selection.
// ----------------------------------------------------------------------------
package fpt_pkg;

    localparam int TABLE_SLOTS       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = $clog2(TABLE_SLOTS);
    localparam int CNT_W             = $clog2(TABLE_SLOTS + 1);
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int MEM_DEPTH         = TABLE_SLOTS * ENTRIES_PER_TABLE;
    localparam int MEM_AW            = $clog2(MEM_DEPTH);
    localparam int FRAME_W           = 40;

    localparam logic [1:0] CMD_MAP       = 2'd0;
    localparam logic [1:0] CMD_UNMAP     = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_NOMEM  = 2'd2;

    localparam int PTE_PRESENT = 0;
    localparam int PTE_WRITE   = 1;
    localparam int PTE_USER    = 2;
    localparam int PTE_LARGE   = 7;

    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [63:0] page_flags;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] phys_result;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ALLOC,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [FRAME_W-1:0] a;
        logic [FRAME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [FRAME_W-1:0] sum;
        logic               in_pool;
        logic [SLOT_W-1:0]  slot;
    } t_alu_res;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [63:0]       wdata;
    } t_ram_req;

    function automatic logic [IDX_W-1:0] fpt_index(input logic [47:0] va,
                                                   input logic [1:0]  lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/fpt_ram.sv =====
// ----------------------------------------------------------------------------
// fpt_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module fpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpt_alu.sv =====
// ----------------------------------------------------------------------------
// fpt_alu: shared frame adder and pool range check
// Forms table addresses from the pool base and maps frame numbers to slots.
// ----------------------------------------------------------------------------
module fpt_alu (
    input  fpt_pkg::t_alu_req i_req,
    output fpt_pkg::t_alu_res o_res
);

    import fpt_pkg::*;

    logic [FRAME_W-1:0] w_b;
    logic [FRAME_W:0]   w_sum;

    always_comb begin
        w_b   = (i_req.op == ALU_SUB) ? ~i_req.b : i_req.b;
        w_sum = {1'b0, i_req.a} + {1'b0, w_b} + {{FRAME_W{1'b0}}, (i_req.op == ALU_SUB)};
        o_res.sum     = w_sum[FRAME_W-1:0];
        o_res.in_pool = w_sum[FRAME_W] && (w_sum[FRAME_W-1:0] < FRAME_W'(TABLE_SLOTS));
        o_res.slot    = w_sum[SLOT_W-1:0];
    end

endmodule

// ===== rtl/fpt_walk.sv =====
// ----------------------------------------------------------------------------
// fpt_walk: table walk sequencer
// Clears the pool, walks the levels, allocates tables and holds the result.
// ----------------------------------------------------------------------------
module fpt_walk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  fpt_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output fpt_pkg::t_out_item        o_out_data,
    input  logic [fpt_pkg::FRAME_W-1:0] i_pool_frame,
    output fpt_pkg::t_ram_req         o_ram,
    input  logic [63:0]               i_ram_rdata
);

    import fpt_pkg::*;

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic [1:0]        r_lvl, n_lvl;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [63:0]       r_entry, n_entry;
    logic [CNT_W-1:0]  r_next_free, n_next_free;
    logic [MEM_AW-1:0] r_clr, n_clr;
    logic [1:0]        r_status, n_status;
    logic [51:0]       r_result, n_result;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_alu_req          w_alu_req;
    t_alu_res          w_alu_res;
    logic [SLOT_W-1:0] w_slot;
    logic              w_slot_ok;
    logic [IDX_W-1:0]  w_idx;

    fpt_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
        r_item   <= n_item;
        r_lvl    <= n_lvl;
        r_slot   <= n_slot;
        r_entry  <= n_entry;
        r_status <= n_status;
        r_result <= n_result;
        r_out    <= n_out;
    end

    always_comb begin
        w_alu_req.op = ALU_SUB;
        w_alu_req.a  = r_entry[51:12];
        w_alu_req.b  = i_pool_frame;
        if (r_state == S_ALLOC) begin
            w_alu_req.op = ALU_ADD;
            w_alu_req.a  = i_pool_frame;
            w_alu_req.b  = FRAME_W'(r_next_free);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_lvl       = r_lvl;
        n_slot      = r_slot;
        n_entry     = r_entry;
        n_next_free = r_next_free;
        n_clr       = r_clr;
        n_status    = r_status;
        n_result    = r_result;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        w_idx         = fpt_index(r_item.virt_addr, r_lvl);
        w_slot        = (r_lvl == 2'd0) ? '0 : w_alu_res.slot;
        w_slot_ok     = (r_lvl == 2'd0) || w_alu_res.in_pool;
        o_ram.we      = 1'b0;
        o_ram.addr    = MEM_AW'({r_slot, w_idx});
        o_ram.wdata   = '0;
        o_in_ready    = (r_state == S_IDLE);

        unique case (r_state)
            S_CLEAR: begin
                o_ram.we   = 1'b1;
                o_ram.addr = r_clr;
                if (r_clr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + MEM_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_data;
                    n_lvl    = 2'd0;
                    n_result = '0;
                    if (i_in_data.command == CMD_MAP || i_in_data.command == CMD_UNMAP ||
                        i_in_data.command == CMD_TRANSLATE) begin
                        n_state = S_READ;
                    end else begin
                        n_status = ST_ABSENT;
                        n_state  = S_DONE;
                    end
                end
            end
            S_READ: begin
                o_ram.addr = MEM_AW'({w_slot, w_idx});
                if (!w_slot_ok) begin
                    n_status = ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    n_slot = w_slot;
                    if (r_lvl == LVL_LEAF && r_item.command == CMD_MAP) begin
                        o_ram.we    = 1'b1;
                        o_ram.wdata = {12'b0, r_item.phys_addr[51:12], 12'b0}
                                      | r_item.page_flags | 64'd1;
                        n_status    = ST_OK;
                        n_state     = S_DONE;
                    end else if (r_lvl == LVL_LEAF && r_item.command == CMD_UNMAP) begin
                        o_ram.we = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                n_entry = i_ram_rdata;
                if (!i_ram_rdata[PTE_PRESENT]) begin
                    if (r_item.command == CMD_MAP) begin
                        n_state = S_ALLOC;
                    end else begin
                        n_status = ST_ABSENT;
                        n_state  = S_DONE;
                    end
                end else if (r_item.command == CMD_TRANSLATE && r_lvl == LVL_PDPT &&
                             i_ram_rdata[PTE_LARGE]) begin
                    n_result = {i_ram_rdata[51:30], r_item.virt_addr[29:0]};
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (r_item.command == CMD_TRANSLATE && r_lvl == LVL_PD &&
                             i_ram_rdata[PTE_LARGE]) begin
                    n_result = {i_ram_rdata[51:21], r_item.virt_addr[20:0]};
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else if (r_lvl == LVL_LEAF) begin
                    n_result = {i_ram_rdata[51:12], r_item.virt_addr[11:0]};
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_lvl   = r_lvl + 2'd1;
                    n_state = S_READ;
                end
            end
            S_ALLOC: begin
                if (r_next_free >= CNT_W'(TABLE_SLOTS)) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = {12'b0, w_alu_res.sum, 12'b0} | 64'h3
                                  | (r_item.page_flags & 64'h4);
                    n_entry     = o_ram.wdata;
                    n_next_free = r_next_free + CNT_W'(1);
                    n_lvl       = r_lvl + 2'd1;
                    n_state     = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.phys_result = r_result;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker: four-level page-table engine
// Map, unmap and translate over a local pool of tables, slot 0 as the root.
// ----------------------------------------------------------------------------
// Each table level walked passes a read and an evaluate state; an allocated table
// adds an allocate state, a map or unmap writes its leaf entry in the read state of
// the leaf level and the done state loads the result. The next item is accepted
// in the same cycle as its result appears, later while the previous result still waits.
// After reset a clearing pass zeroes all 8192 entries of the table memory; no item
// is accepted meanwhile, while the configuration register is always writable.
// ----------------------------------------------------------------------------
module four_level_page_table_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fpt_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fpt_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [51:0]       i_cfg_data
);

    import fpt_pkg::*;

    logic [FRAME_W-1:0] r_pool_frame;
    t_ram_req           w_ram;
    logic [63:0]        w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_frame <= '0;
        end else if (i_cfg_valid) begin
            r_pool_frame <= i_cfg_data[51:12];
        end
    end

    assign o_cfg_ready = 1'b1;

    fpt_ram #(
        .WIDTH (64),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_addr  (w_ram.addr),
        .i_wdata (w_ram.wdata),
        .o_rdata (w_ram_rdata)
    );

    fpt_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .i_pool_frame (r_pool_frame),
        .o_ram        (w_ram),
        .i_ram_rdata  (w_ram_rdata)
    );

endmodule

// ===== dv/fpt_walk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpt_walk_checker: result checker for the four-level page-table walker
// Watches the command, result and base-register channels, keeps its own copy
// of the table pool and the slot counter, predicts the status and address of
// every accepted command and compares each returned item in order.
// ----------------------------------------------------------------------------
module fpt_walk_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  fpt_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  fpt_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [51:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] WRAP_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] GIG_FRAME = 64'h000F_FFFF_C000_0000;
    localparam logic [63:0] GIG_OFF   = 64'h0000_0000_3FFF_FFFF;
    localparam logic [63:0] MEG_FRAME = 64'h000F_FFFF_FFE0_0000;
    localparam logic [63:0] MEG_OFF   = 64'h0000_0000_001F_FFFF;
    localparam logic [63:0] PAGE_OFF  = 64'h0000_0000_0000_0FFF;
    localparam int          LEAF      = int'(fpt_pkg::LVL_LEAF);

    logic [63:0]        pt_mem [0:fpt_pkg::MEM_DEPTH-1];
    int                 next_slot;
    logic [63:0]        pool_addr;
    fpt_pkg::t_out_item walk_results_q [$];
    int                 err_count = 0;

    function automatic int entry_pos(input int slot, input logic [47:0] va, input int lvl);
        logic [47:0] sh;
        sh = va >> (39 - 9 * lvl);
        return slot * fpt_pkg::ENTRIES_PER_TABLE + int'(sh[8:0]);
    endfunction

    // Slot named by the address field of an entry, or -1 outside the pool.
    function automatic int pool_slot(input logic [63:0] ent);
        logic [63:0] addr;
        logic [63:0] slot_off;
        addr = ent & ADDR_MASK;
        if (addr < pool_addr) return -1;
        slot_off = (addr - pool_addr) >> 12;
        if (slot_off >= 64'(fpt_pkg::TABLE_SLOTS)) return -1;
        return int'(slot_off);
    endfunction

    task automatic walk_item(input fpt_pkg::t_in_item it, output fpt_pkg::t_out_item res);
        int          slot;
        int          pos;
        int          lvl;
        int          nxt;
        logic [63:0] ent;
        logic [63:0] va;
        bit          done;
        slot = 0;
        done = 1'b0;
        va   = 64'(it.virt_addr);
        res.status      = fpt_pkg::ST_OK;
        res.phys_result = '0;
        case (it.command)
            fpt_pkg::CMD_MAP: begin
                for (lvl = 0; lvl < LEAF && !done; lvl++) begin
                    pos = entry_pos(slot, it.virt_addr, lvl);
                    ent = pt_mem[pos];
                    if (!ent[fpt_pkg::PTE_PRESENT]) begin
                        if (next_slot >= fpt_pkg::TABLE_SLOTS) begin
                            res.status = fpt_pkg::ST_NOMEM;
                            done = 1'b1;
                        end else begin
                            ent = (pool_addr + (64'(next_slot) << 12)) & WRAP_MASK;
                            ent[fpt_pkg::PTE_PRESENT] = 1'b1;
                            ent[fpt_pkg::PTE_WRITE]   = 1'b1;
                            ent[fpt_pkg::PTE_USER]    = it.page_flags[fpt_pkg::PTE_USER];
                            pt_mem[pos] = ent;
                            next_slot++;
                        end
                    end
                    if (!done) begin
                        nxt = pool_slot(ent);
                        if (nxt < 0) begin
                            res.status = fpt_pkg::ST_ABSENT;
                            done = 1'b1;
                        end else begin
                            slot = nxt;
                        end
                    end
                end
                if (!done) begin
                    ent = (64'(it.phys_addr) & ADDR_MASK) | it.page_flags;
                    ent[fpt_pkg::PTE_PRESENT] = 1'b1;
                    pt_mem[entry_pos(slot, it.virt_addr, LEAF)] = ent;
                end
            end
            fpt_pkg::CMD_UNMAP: begin
                for (lvl = 0; lvl < LEAF && !done; lvl++) begin
                    ent = pt_mem[entry_pos(slot, it.virt_addr, lvl)];
                    nxt = ent[fpt_pkg::PTE_PRESENT] ? pool_slot(ent) : -1;
                    if (nxt < 0) begin
                        res.status = fpt_pkg::ST_ABSENT;
                        done = 1'b1;
                    end else begin
                        slot = nxt;
                    end
                end
                if (!done) pt_mem[entry_pos(slot, it.virt_addr, LEAF)] = '0;
            end
            fpt_pkg::CMD_TRANSLATE: begin
                for (lvl = 0; lvl < LEAF && !done; lvl++) begin
                    ent = pt_mem[entry_pos(slot, it.virt_addr, lvl)];
                    if (!ent[fpt_pkg::PTE_PRESENT]) begin
                        res.status = fpt_pkg::ST_ABSENT;
                        done = 1'b1;
                    end else if (lvl == int'(fpt_pkg::LVL_PDPT) && ent[fpt_pkg::PTE_LARGE]) begin
                        res.phys_result = 52'((ent & GIG_FRAME) | (va & GIG_OFF));
                        done = 1'b1;
                    end else if (lvl == int'(fpt_pkg::LVL_PD) && ent[fpt_pkg::PTE_LARGE]) begin
                        res.phys_result = 52'((ent & MEG_FRAME) | (va & MEG_OFF));
                        done = 1'b1;
                    end else begin
                        nxt = pool_slot(ent);
                        if (nxt < 0) begin
                            res.status = fpt_pkg::ST_ABSENT;
                            done = 1'b1;
                        end else begin
                            slot = nxt;
                        end
                    end
                end
                if (!done) begin
                    ent = pt_mem[entry_pos(slot, it.virt_addr, LEAF)];
                    if (!ent[fpt_pkg::PTE_PRESENT]) begin
                        res.status = fpt_pkg::ST_ABSENT;
                    end else begin
                        res.phys_result = 52'((ent & ADDR_MASK) | (va & PAGE_OFF));
                    end
                end
            end
            default: begin
                res.status = fpt_pkg::ST_ABSENT;
            end
        endcase
    endtask

    task automatic report_err(input string what, input logic [63:0] got, input logic [63:0] want);
        if (err_count < 50) begin
            $display("fpt_walk_checker: %s mismatch, got %h expected %h at %0t",
                     what, got, want, $realtime);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin : watch
        fpt_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < fpt_pkg::MEM_DEPTH; k++) pt_mem[k] = '0;
            next_slot = 1;
            pool_addr = '0;
            walk_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                pool_addr = {12'h000, i_cfg_data[51:12], 12'h000};
            end
            if (i_in_valid && i_in_ready) begin
                walk_item(i_in_data, want);
                walk_results_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (walk_results_q.size() == 0) begin
                    report_err("unexpected item", 64'(i_out_data), '0);
                end else begin
                    want = walk_results_q.pop_front();
                    if (i_out_data.status != want.status) begin
                        report_err("status", 64'(i_out_data.status), 64'(want.status));
                    end
                    if (i_out_data.phys_result != want.phys_result) begin
                        report_err("phys_result", 64'(i_out_data.phys_result),
                                   64'(want.phys_result));
                    end
                end
            end
        end
        o_pending <= walk_results_q.size();
        o_errors  <= err_count;
    end

endmodule

// ===== dv/tb_four_level_page_table_walker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker: testbench for the page-table walker
// Drives map, unmap, translate and spare commands through a directed opening and a
// long random run over a few table regions, self-referencing root entries and
// several pool bases, with bursty commands and a stalling result side.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker;

    localparam int          MAIN_ITEMS  = 1350;
    localparam int          SHIFT_ITEMS = 150;
    localparam int          LATE_ITEMS  = 80;
    localparam int          DRAIN_EVERY = 250;
    localparam logic [1:0]  CMD_SPARE   = 2'd3;
    localparam logic [51:0] BASE_MID    = 52'h1_2345_6789_A000;
    localparam logic [47:0] VA_MID      = {9'h080, 9'h001, 9'h002, 9'h003, 12'hABC};
    localparam int          RX_OPEN     = 0;
    localparam int          RX_RANDOM   = 1;
    localparam int          RX_SHUT     = 2;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    fpt_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    fpt_pkg::t_out_item out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [51:0]        cfg_data;
    int                 err_total;
    int                 pending;
    logic [47:0]        mapped_va_q [$];
    int                 burst_left;

    four_level_page_table_walker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    fpt_walk_checker u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (err_total),
        .o_pending   (pending)
    );

    initial clk = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Walk prefixes reused by most maps; those starting at 0x1FF go back
    // through the self-referencing root entry.
    function automatic logic [26:0] region_prefix(input int r);
        case (r)
            0:       return {9'h000, 9'h000, 9'h000};
            1:       return {9'h000, 9'h000, 9'h001};
            2:       return {9'h000, 9'h005, 9'h007};
            3:       return {9'h1FF, 9'h1FF, 9'h1FF};
            4:       return {9'h1FF, 9'h000, 9'h000};
            default: return {9'h1FF, 9'h1FF, 9'h000};
        endcase
    endfunction

    function automatic logic [47:0] region_va();
        logic [26:0] pre;
        logic [8:0]  leaf;
        pre = region_prefix($urandom_range(0, 5));
        if (pre[26:18] == 9'h1FF) leaf = 9'($urandom_range(9'h100, 9'h1FE));
        else leaf = 9'($urandom);
        return {pre, leaf, 12'($urandom)};
    endfunction

    function automatic logic [47:0] known_va();
        logic [47:0] va;
        if (mapped_va_q.size() != 0 && $urandom_range(0, 9) < 7) begin
            va = mapped_va_q[$urandom_range(0, mapped_va_q.size() - 1)];
            return {va[47:12], 12'($urandom)};
        end
        if ($urandom_range(0, 1) == 0) return region_va();
        return 48'(rand64());
    endfunction

    task automatic issue(input logic [1:0] cmd, input logic [47:0] va,
                         input logic [51:0] pa, input logic [63:0] flags);
        fpt_pkg::t_in_item it;
        int                gap;
        it.command    = cmd;
        it.virt_addr  = va;
        it.phys_addr  = pa;
        it.page_flags = flags;
        if (cmd == fpt_pkg::CMD_MAP) begin
            if (mapped_va_q.size() < 48) mapped_va_q.push_back(va);
            else mapped_va_q[$urandom_range(0, 47)] = va;
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic issue_random();
        logic [1:0]  cmd;
        logic [47:0] va;
        logic [63:0] flags;
        int          pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       flags = '0;
            1:       flags = '1;
            default: flags = rand64();
        endcase
        if (pick < 36) begin
            cmd = fpt_pkg::CMD_MAP;
            va  = ($urandom_range(0, 9) == 0) ? 48'(rand64()) : region_va();
        end else if (pick < 52) begin
            cmd = fpt_pkg::CMD_UNMAP;
            va  = known_va();
        end else if (pick < 97) begin
            cmd = fpt_pkg::CMD_TRANSLATE;
            va  = known_va();
            // Strip self-referencing indices to look at a table as a page.
            while (va[47:39] == 9'h1FF && $urandom_range(0, 2) != 0) begin
                va = {va[38:0], 9'($urandom)};
            end
        end else begin
            cmd = CMD_SPARE;
            va  = 48'(rand64());
        end
        issue(cmd, va, 52'(rand64()), flags);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_base(input logic [51:0] base);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : rx_side
        int rx_mode;
        int rx_left;
        out_ready <= 1'b0;
        rx_mode = RX_OPEN;
        rx_left = 0;
        forever begin
            @(posedge clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_SHUT);
                rx_left = (rx_mode == RX_SHUT) ? $urandom_range(1, 10) : $urandom_range(1, 50);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_RANDOM: out_ready <= 1'($urandom);
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    initial begin
        #5_000_000;
        $display("tb_four_level_page_table_walker: done, errors");
        $finish;
    end

    initial begin
        in_valid   <= 1'b0;
        in_data    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Top base: the first allocated table address wraps to zero.
        write_base('1);
        issue(fpt_pkg::CMD_TRANSLATE, '0, '0, '0);
        issue(fpt_pkg::CMD_UNMAP, '0, '0, '0);
        issue(CMD_SPARE, '1, '1, '1);
        issue(fpt_pkg::CMD_MAP, '1, '1, '1);
        issue(fpt_pkg::CMD_TRANSLATE, '1, '0, '0);
        issue(fpt_pkg::CMD_UNMAP, '1, '0, '0);
        wait_drain();

        write_base(BASE_MID);
        issue(fpt_pkg::CMD_MAP, VA_MID, '0, '0);
        issue(fpt_pkg::CMD_TRANSLATE, VA_MID, '0, '0);
        issue(fpt_pkg::CMD_UNMAP, VA_MID, '0, '0);
        issue(fpt_pkg::CMD_TRANSLATE, VA_MID, '0, '0);
        issue(fpt_pkg::CMD_UNMAP, VA_MID, '0, '0);
        issue(fpt_pkg::CMD_MAP, VA_MID, '1, 64'h4);
        issue(fpt_pkg::CMD_TRANSLATE, VA_MID | 48'hFFF, '0, '0);
        issue(fpt_pkg::CMD_TRANSLATE, '1, '0, '0);
        wait_drain();

        // Zero base: the wrapped root entry now points back at the root.
        write_base('0);
        issue(fpt_pkg::CMD_TRANSLATE, VA_MID, '0, '0);
        issue(fpt_pkg::CMD_MAP, '0, 52'(rand64()), '0);
        issue(fpt_pkg::CMD_MAP, {9'h000, 9'h000, 9'h001, 9'h1FF, 12'h000},
              52'(rand64()), rand64());
        issue(fpt_pkg::CMD_MAP, {9'h000, 9'h005, 9'h007, 9'h0AA, 12'h000},
              52'(rand64()), rand64());
        issue(fpt_pkg::CMD_MAP, {9'h1FF, 9'h1FF, 9'h1FF, 9'h150, 12'h000},
              52'(rand64()), 64'h81);
        issue(fpt_pkg::CMD_MAP, {9'h1FF, 9'h1FF, 9'h000, 9'h120, 12'h000},
              52'hA_BCDE_4000_0000, 64'h80);
        issue(fpt_pkg::CMD_TRANSLATE, {9'h000, 9'h120, 30'($urandom)}, '0, '0);
        issue(fpt_pkg::CMD_MAP, {9'h1FF, 9'h000, 9'h000, 9'h130, 12'h000},
              52'(rand64()), 64'h80);
        issue(fpt_pkg::CMD_TRANSLATE, {9'h000, 9'h000, 9'h130, 21'($urandom)}, '0, '0);
        issue(fpt_pkg::CMD_TRANSLATE, 48'hFFF, '0, '0);

        for (int n = 0; n < MAIN_ITEMS; n++) begin
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drain();
            issue_random();
        end
        wait_drain();

        // Base moved by one slot: existing pointers land on other tables.
        write_base({40'h0_0000_0001, 12'($urandom)});
        for (int n = 0; n < SHIFT_ITEMS; n++) issue_random();
        wait_drain();

        write_base(52'(rand64()));
        for (int n = 0; n < LATE_ITEMS; n++) issue_random();
        wait_drain();

        repeat (20) @(posedge clk);
        if (err_total == 0 && pending == 0) begin
            $display("tb_four_level_page_table_walker: done, clean");
        end else begin
            $display("tb_four_level_page_table_walker: done, errors");
        end
        $finish;
    end

endmodule
